@@ hw/rtl/ascii85_stream_decoder_macros.svh @@
// assertion macros for the ascii85 stream decoder
`ifndef ASCII85_STREAM_DECODER_MACROS_SVH
`define ASCII85_STREAM_DECODER_MACROS_SVH

// invariant that holds at every clock edge out of reset
`define A85_CHECK(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// condition in this cycle implies a consequence in the same cycle
`define A85_CHECK_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// condition in this cycle implies a consequence in the next cycle
`define A85_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/a85_pkg.sv @@
// constants and helpers for the ascii85 stream decoder
`timescale 1ns / 1ps

package a85_pkg;

    // width of the character offset counter, saturates at all ones
    localparam int OFFSET_BITS = 32;
    localparam int OFF_W       = (OFFSET_BITS < 32) ? OFFSET_BITS : 32;

    // character codes
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_FIRST = 8'h21;
    localparam logic [7:0] CH_LAST  = 8'h75;
    localparam logic [7:0] CH_ZERO  = 8'h7a;

    localparam logic [31:0] BASE = 32'd85;

    // bytes in a full group
    localparam logic [2:0] GROUP_BYTES = 3'd4;

    typedef logic [2:0] t_dcnt;

    // scale for padding a partial group of n digits with the top digit:
    // v = (acc + 1) * 85^(5-n) - 1
    function automatic logic [19:0] pad_scale(input t_dcnt dcnt);
        logic [19:0] s;
        unique case (dcnt)
            3'd2:    s = 20'd614125;
            3'd3:    s = 20'd7225;
            default: s = 20'd85;
        endcase
        return s;
    endfunction

endpackage

@@ hw/rtl/ascii85_stream_decoder.sv @@
// ascii85 stream decoder: one character per beat in, decoded bytes out
//
//  channel  | dir | tdata                              | tuser       | tlast
//  ---------+-----+------------------------------------+-------------+------------
//  s_axis   | in  | [7:0] in_char                      | flush       | -
//  m_axis   | out | [7:0] out_byte, [39:8] error_offset | is_error    | last of item
//
// one input beat per cycle unless stalled: a character is decoded from the input
// register, and beats that give no output never wait on the output side.
// a beat that gives output needs the group register free; a group of n
// bytes drains one beat per cycle while m_axis_tready is high.
// reset (i_rst_n low, synchronous) clears the decoder state and both registers.
// m_axis_tready low holds the group register and, once the input register
// holds an item with output, stalls s_axis.
`timescale 1ns / 1ps

module ascii85_stream_decoder
    import a85_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_char
    input  logic        s_axis_tuser,   // [0] flush
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [7:0] out_byte, [39:8] error_offset
    output logic        m_axis_tuser,   // [0] is_error
    output logic        m_axis_tlast
);

`include "ascii85_stream_decoder_macros.svh"

    // input register
    logic              r_in_valid;
    logic [7:0]        r_in_char;
    logic              r_in_flush;

    // decoder state
    logic [31:0]       r_acc;
    t_dcnt             r_dcnt;
    logic [OFF_W-1:0]  r_offset;
    logic              r_err_latched;

    // result group register
    logic              r_grp_valid;
    logic [31:0]       r_grp_word;
    logic [2:0]        r_grp_cnt;
    logic              r_grp_err;
    logic [31:0]       r_grp_off;

    // next values
    logic [31:0]       n_acc;
    t_dcnt             n_dcnt;
    logic [OFF_W-1:0]  n_offset;
    logic              n_err_latched;

    logic              w_has_grp;
    logic [31:0]       w_grp_word;
    logic [2:0]        w_grp_cnt;
    logic              w_grp_err;
    logic [31:0]       w_grp_off;

    logic              w_is_ws;
    logic              w_is_digit;
    logic              w_is_bad;
    logic [31:0]       w_digit_acc;
    logic [31:0]       w_pad_word;
    logic              w_grp_free;
    logic              w_proc;
    logic              s_fire;
    logic              m_fire;

    // character classes
    assign w_is_ws    = (r_in_char <= CH_SPACE);
    assign w_is_digit = (r_in_char >= CH_FIRST) && (r_in_char <= CH_LAST);
    assign w_is_bad   = !r_in_flush && !r_err_latched && !w_is_ws && !w_is_digit
                        && !((r_in_char == CH_ZERO) && (r_dcnt == 3'd0));

    // accumulator with a new digit, and a partial group padded at flush
    assign w_digit_acc = r_acc * BASE + {25'd0, 7'(r_in_char - CH_FIRST)};
    assign w_pad_word  = 32'((r_acc + 32'd1) * {12'd0, pad_scale(r_dcnt)}) - 32'd1;

    // decode one item
    always_comb begin
        n_acc         = r_acc;
        n_dcnt        = r_dcnt;
        n_offset      = r_offset;
        n_err_latched = r_err_latched;
        w_has_grp     = 1'b0;
        w_grp_word    = 32'd0;
        w_grp_cnt     = 3'd1;
        w_grp_err     = 1'b0;
        w_grp_off     = 32'd0;
        if (r_in_flush) begin
            if (!r_err_latched) begin
                if (r_dcnt == 3'd1) begin
                    w_has_grp = 1'b1;
                    w_grp_err = 1'b1;
                    w_grp_off = 32'(r_offset);
                end else if (r_dcnt >= 3'd2) begin
                    w_has_grp  = 1'b1;
                    w_grp_word = w_pad_word;
                    w_grp_cnt  = r_dcnt - 3'd1;
                end
            end
            n_acc         = 32'd0;
            n_dcnt        = 3'd0;
            n_offset      = '0;
            n_err_latched = 1'b0;
        end else begin
            if (r_offset != {OFF_W{1'b1}}) begin
                n_offset = r_offset + OFF_W'(1);
            end
            if (!r_err_latched && !w_is_ws) begin
                if ((r_in_char == CH_ZERO) && (r_dcnt == 3'd0)) begin
                    w_has_grp = 1'b1;
                    w_grp_cnt = GROUP_BYTES;
                end else if (w_is_digit) begin
                    if (r_dcnt == GROUP_BYTES) begin
                        w_has_grp  = 1'b1;
                        w_grp_word = w_digit_acc;
                        w_grp_cnt  = GROUP_BYTES;
                        n_acc      = 32'd0;
                        n_dcnt     = 3'd0;
                    end else begin
                        n_acc  = w_digit_acc;
                        n_dcnt = r_dcnt + 3'd1;
                    end
                end else begin
                    n_err_latched = 1'b1;
                    w_has_grp     = 1'b1;
                    w_grp_err     = 1'b1;
                    w_grp_off     = 32'(r_offset);
                end
            end
        end
    end

    // handshakes
    assign w_grp_free    = !r_grp_valid || (m_axis_tready && (r_grp_cnt == 3'd1));
    assign w_proc        = r_in_valid && (!w_has_grp || w_grp_free);
    assign s_axis_tready = !r_in_valid || w_proc;
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign m_fire        = m_axis_tvalid && m_axis_tready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_fire) begin
            r_in_valid <= 1'b1;
        end else if (w_proc) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_in_char  <= s_axis_tdata;
            r_in_flush <= s_axis_tuser;
        end
    end

    // decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc         <= 32'd0;
            r_dcnt        <= 3'd0;
            r_offset      <= '0;
            r_err_latched <= 1'b0;
        end else if (w_proc) begin
            r_acc         <= n_acc;
            r_dcnt        <= n_dcnt;
            r_offset      <= n_offset;
            r_err_latched <= n_err_latched;
        end
    end

    // result group register, drained one byte per beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grp_valid <= 1'b0;
            r_grp_cnt   <= 3'd1;
        end else if (w_proc && w_has_grp) begin
            r_grp_valid <= 1'b1;
            r_grp_cnt   <= w_grp_cnt;
        end else if (m_fire) begin
            if (r_grp_cnt == 3'd1) begin
                r_grp_valid <= 1'b0;
            end else begin
                r_grp_cnt <= r_grp_cnt - 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_proc && w_has_grp) begin
            r_grp_word <= w_grp_word;
            r_grp_err  <= w_grp_err;
            r_grp_off  <= w_grp_off;
        end else if (m_fire) begin
            r_grp_word <= {r_grp_word[23:0], 8'd0};
        end
    end

    // output beat
    assign m_axis_tvalid = r_grp_valid;
    assign m_axis_tdata  = {r_grp_off, r_grp_word[31:24]};
    assign m_axis_tuser  = r_grp_err;
    assign m_axis_tlast  = (r_grp_cnt == 3'd1);

    // checks
    `A85_CHECK(a_dcnt_range, r_dcnt <= GROUP_BYTES, "digit count above four")
    `A85_CHECK_NOW(a_grp_cnt_range, r_grp_valid, (r_grp_cnt != 3'd0) && (r_grp_cnt <= GROUP_BYTES),
        "group byte count out of range")
    `A85_CHECK_NOW(a_err_single, r_grp_valid && r_grp_err,
        (r_grp_cnt == 3'd1) && (r_grp_word == 32'd0), "error beat not a single zero beat")
    `A85_CHECK_NEXT(a_err_latches, w_proc && w_is_bad, r_err_latched && r_grp_valid && r_grp_err,
        "bad character did not latch an error")
    `A85_CHECK_NEXT(a_state_held, r_in_valid && !w_proc, $stable(r_offset) && $stable(r_acc),
        "decoder state moved without an item")

endmodule
